FILE: rtl/stream_cipher_keystream_xor_assert.svh
// Assertion macros for the keystream XOR block.
// Included by the top level; no other dependencies.
`ifndef STREAM_CIPHER_KEYSTREAM_XOR_ASSERT_SVH
`define STREAM_CIPHER_KEYSTREAM_XOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define SCKX_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SCKX_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SCKX_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define SCKX_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/sckx_pkg.sv
// Types, constants and helper functions for the keystream XOR block.
// No dependencies; used by sckx_cfg, sckx_core and the top level.
package sckx_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;
  localparam int BLK_NUM_W = 26;

  localparam logic [2:0] REG_KEY_0_63    = 3'd0;
  localparam logic [2:0] REG_KEY_64_127  = 3'd1;
  localparam logic [2:0] REG_KEY_128_191 = 3'd2;
  localparam logic [2:0] REG_KEY_192_255 = 3'd3;
  localparam logic [2:0] REG_KEY_MODE    = 3'd4;
  localparam logic [2:0] REG_NONCE       = 3'd5;
  localparam logic [2:0] REG_START_POS   = 3'd6;

  localparam logic [31:0] EXPA   = 32'h61707865;
  localparam logic [31:0] TE_K   = 32'h6b206574;
  localparam logic [31:0] ND_3   = 32'h3320646e;
  localparam logic [31:0] TWO_BY = 32'h79622d32;
  localparam logic [31:0] ND_1   = 32'h3120646e;
  localparam logic [31:0] SIX_BY = 32'h79622d36;

  typedef logic [15:0][31:0] block_t;

  typedef struct packed {
    logic [63:0] key0;
    logic [63:0] key1;
    logic [63:0] key2;
    logic [63:0] key3;
    logic        mode;
    logic [63:0] nonce;
    logic [31:0] start;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [BLK_NUM_W-1:0] block_num;
  } core_req_t;

  typedef enum logic [1:0] {T_IDLE, T_BLOCK, T_XOR} top_state_t;
  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} core_state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // word index of role (0 a, 1 b, 2 c, 3 d) in column quarter round of lane
  function automatic logic [3:0] col_idx(input int unsigned lane, input int unsigned role);
    return 4'((5 * lane + 4 * role) % 16);
  endfunction

  function automatic block_t init_words(input cfg_t c, input logic [BLK_NUM_W-1:0] blk);
    block_t      w;
    logic [63:0] hk0;
    logic [63:0] hk1;
    hk0   = c.mode ? c.key2 : c.key0;
    hk1   = c.mode ? c.key3 : c.key1;
    w[0]  = EXPA;
    w[1]  = c.key0[31:0];
    w[2]  = c.key0[63:32];
    w[3]  = c.key1[31:0];
    w[4]  = c.key1[63:32];
    w[5]  = c.mode ? ND_3 : ND_1;
    w[6]  = c.nonce[31:0];
    w[7]  = c.nonce[63:32];
    w[8]  = {6'd0, blk};
    w[9]  = 32'd0;
    w[10] = c.mode ? TWO_BY : SIX_BY;
    w[11] = hk0[31:0];
    w[12] = hk0[63:32];
    w[13] = hk1[31:0];
    w[14] = hk1[63:32];
    w[15] = TE_K;
    return w;
  endfunction

endpackage

FILE: rtl/sckx_in_if.sv
// Input word channel: valid/ready handshake with a data byte and message flags.
// No dependencies.
interface sckx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       first_of_message;
  logic       last_of_message;

  modport source (output valid, data_in, first_of_message, last_of_message, input ready);
  modport sink (input valid, data_in, first_of_message, last_of_message, output ready);
endinterface

FILE: rtl/sckx_out_if.sv
// Output word channel: valid/ready handshake with the result byte and last flag.
// No dependencies.
interface sckx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       last_out;

  modport source (output valid, data_out, last_out, input ready);
  modport sink (input valid, data_out, last_out, output ready);
endinterface

FILE: rtl/sckx_cfg.sv
// APB configuration register file for the keystream XOR block.
// Depends on sckx_pkg.
module sckx_cfg
  import sckx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key0  <= '0;
      cfg.key1  <= '0;
      cfg.key2  <= '0;
      cfg.key3  <= '0;
      cfg.mode  <= 1'b1;
      cfg.nonce <= '0;
      cfg.start <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_KEY_0_63:    cfg.key0  <= pwdata;
        REG_KEY_64_127:  cfg.key1  <= pwdata;
        REG_KEY_128_191: cfg.key2  <= pwdata;
        REG_KEY_192_255: cfg.key3  <= pwdata;
        REG_KEY_MODE:    cfg.mode  <= pwdata[0];
        REG_NONCE:       cfg.nonce <= pwdata;
        REG_START_POS:   cfg.start <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY_0_63:    prdata = cfg.key0;
      REG_KEY_64_127:  prdata = cfg.key1;
      REG_KEY_128_191: prdata = cfg.key2;
      REG_KEY_192_255: prdata = cfg.key3;
      REG_KEY_MODE:    prdata = {63'd0, cfg.mode};
      REG_NONCE:       prdata = cfg.nonce;
      REG_START_POS:   prdata = {32'd0, cfg.start};
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/sckx_core.sv
// Keystream block generator: four add-rotate-xor lanes reused over every
// step of every half round, with a transpose after each half round.
// Depends on sckx_pkg.
module sckx_core
  import sckx_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  core_req_t req,
  input  logic [5:0] rd_pos,
  output logic [7:0] ks_byte,
  output logic      done
);

  localparam int HALF_W = $clog2(2 * DOUBLE_ROUNDS);
  localparam logic [HALF_W-1:0] LAST_HALF = HALF_W'(2 * DOUBLE_ROUNDS - 1);

  core_state_t          state;
  core_state_t          state_next;
  logic [1:0]           step;
  logic [HALF_W-1:0]    half;
  logic [BLK_NUM_W-1:0] blk;
  block_t               round_words;
  block_t               keystream_words;
  block_t               init_w;
  block_t               round_upd;
  block_t               round_next;

  assign init_w  = init_words(cfg, blk);
  assign ks_byte = keystream_words[rd_pos[5:2]][{rd_pos[1:0], 3'b000} +: 8];

  always_comb begin
    unique case (state)
      C_IDLE:  state_next = req.start ? C_ROUND : C_IDLE;
      C_ROUND: state_next = (step == 2'd3 && half == LAST_HALF) ? C_FINAL : C_ROUND;
      C_FINAL: state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_comb begin
    done = (state == C_FINAL);
  end

  always_comb begin
    logic [3:0] ia;
    logic [3:0] ib;
    logic [3:0] ic;
    logic [3:0] id;
    round_upd = round_words;
    for (int unsigned l = 0; l < 4; l++) begin
      ia = col_idx(l, 0);
      ib = col_idx(l, 1);
      ic = col_idx(l, 2);
      id = col_idx(l, 3);
      unique case (step)
        2'd0: round_upd[ib] = round_words[ib] ^ rotl(round_words[ia] + round_words[id], 7);
        2'd1: round_upd[ic] = round_words[ic] ^ rotl(round_words[ib] + round_words[ia], 9);
        2'd2: round_upd[id] = round_words[id] ^ rotl(round_words[ic] + round_words[ib], 13);
        2'd3: round_upd[ia] = round_words[ia] ^ rotl(round_words[id] + round_words[ic], 18);
        default: ;
      endcase
    end
    round_next = round_upd;
    if (step == 2'd3) begin
      for (int unsigned i = 0; i < 4; i++) begin
        for (int unsigned j = 0; j < 4; j++) begin
          round_next[i * 4 + j] = round_upd[j * 4 + i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      step  <= '0;
      half  <= '0;
    end else begin
      state <= state_next;
      if (state == C_IDLE) begin
        step <= '0;
        half <= '0;
      end else if (state == C_ROUND) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          half <= half + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == C_IDLE && req.start) begin
      round_words <= init_words(cfg, req.block_num);
      blk         <= req.block_num;
    end else if (state == C_ROUND) begin
      round_words <= round_next;
    end
    if (state == C_FINAL) begin
      for (int unsigned i = 0; i < 16; i++) begin
        keystream_words[i] <= round_words[i] + init_w[i];
      end
    end
  end

endmodule

FILE: rtl/stream_cipher_keystream_xor.sv
// Top level of the keystream XOR block: byte sequencer, output register,
// configuration port and keystream generator.
// Depends on sckx_pkg, sckx_in_if, sckx_out_if, sckx_cfg, sckx_core.
//
// Use: data bytes enter on rx (valid/ready), each XORed with the keystream
// byte at its stream position, and leave on tx with last_out copied from
// last_of_message. A word with first_of_message restarts the position at
// the start_position register; every other word takes the next position.
// Key, mode, nonce and start position are written over the APB port; the
// user must do so only while no word is in flight, which the block itself
// does not enforce. pready is always high and reads return the value.
// A word inside a keystream block is accepted, then loads the output
// register. A word that opens a block (first of message or position a
// multiple of 64) waits for the round unit: four-lane add-rotate-xor steps
// over both half rounds of each of DOUBLE_ROUNDS double rounds (default 10),
// one final add and the output load. No new word is taken before that load.
// Reset clears the registers (mode to 256-bit), the position to zero and the
// sequencer; the first block is made on the first word. If tx stalls, one
// result is held in the output register and rx takes one more word only once
// that register is being emptied.
module stream_cipher_keystream_xor
  import sckx_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  sckx_in_if.sink               rx,
  sckx_out_if.source            tx,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t        cfg;
  core_req_t   core_req;
  logic        core_done;
  logic [7:0]  ks_byte;
  top_state_t  state;
  top_state_t  state_next;
  logic        accept;
  logic        need_block;
  logic [31:0] pos_sel;
  logic [31:0] stream_position;
  logic [5:0]  pos_q;
  logic [7:0]  data_q;
  logic        last_q;
  logic        out_valid;
  logic [7:0]  out_data;
  logic        out_last;

  sckx_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sckx_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .req     (core_req),
    .rd_pos  (pos_q),
    .ks_byte (ks_byte),
    .done    (core_done)
  );

  assign accept     = rx.valid && rx.ready;
  assign pos_sel    = rx.first_of_message ? cfg.start : stream_position;
  assign need_block = rx.first_of_message || (pos_sel[5:0] == 6'd0);

  assign tx.valid    = out_valid;
  assign tx.data_out = out_data;
  assign tx.last_out = out_last;

  always_comb begin
    unique case (state)
      T_IDLE: begin
        if (accept) begin
          state_next = need_block ? T_BLOCK : T_XOR;
        end else begin
          state_next = T_IDLE;
        end
      end
      T_BLOCK: state_next = core_done ? T_XOR : T_BLOCK;
      T_XOR:   state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    rx.ready           = (state == T_IDLE) && (!out_valid || tx.ready);
    core_req.start     = accept && need_block;
    core_req.block_num = pos_sel[31:6];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= T_IDLE;
      stream_position <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        stream_position <= pos_sel + 32'd1;
      end
      if (state == T_XOR) begin
        out_valid <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_q  <= pos_sel[5:0];
      data_q <= rx.data_in;
      last_q <= rx.last_of_message;
    end
    if (state == T_XOR) begin
      out_data <= data_q ^ ks_byte;
      out_last <= last_q;
    end
  end

`include "stream_cipher_keystream_xor_assert.svh"

  `SCKX_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accept, state != T_IDLE, "word left idle")
  `SCKX_ASSERT_IMPL(a_done_in_block, clk, rst, core_done, state == T_BLOCK, "done while not busy")
  `SCKX_ASSERT_IMPL(a_out_free_on_xor, clk, rst, state == T_XOR, !out_valid, "held word lost")

endmodule
